// ----- rtl/fspc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspc_pkg
// Shared types and constants of the frustum sphere and point cull block.
// ----------------------------------------------------------------------------
package fspc_pkg;

    localparam int NUM_PLANES         = 6;
    localparam int CFG_IDX_W          = 3;
    localparam int PLANE_W            = 64;
    localparam int NORM_W             = 16;
    localparam int OFFS_W             = 16;
    // The offset and the radius are Q8.8; products of Q1.14 and Q8.8 are Q.22.
    localparam int D_SHIFT            = 14;
    localparam int COORD_BITS_DEFAULT = 16;
    localparam int CONT_W             = 2;

    // Register indexes of the plane registers.
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd5;

    localparam logic [CONT_W-1:0] CONT_DISJOINT   = 2'd0;
    localparam logic [CONT_W-1:0] CONT_INTERSECTS = 2'd1;
    localparam logic [CONT_W-1:0] CONT_CONTAINS   = 2'd2;

    // Verdict gathered along the row of plane cells.
    typedef struct packed {
        logic is_point;
        logic disjoint;
        logic all_inside;
    } flags_t;

    function automatic logic [CFG_IDX_W-1:0] plane_reg_index(input int unsigned idx);
        logic [CFG_IDX_W-1:0] code;
        case (idx)
            0:       code = REG_PLANE_NEAR;
            1:       code = REG_PLANE_FAR;
            2:       code = REG_PLANE_LEFT;
            3:       code = REG_PLANE_RIGHT;
            4:       code = REG_PLANE_TOP;
            default: code = REG_PLANE_BOTTOM;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/fspc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fspc_cell
// One plane of the frustum: holds the plane register, forms the signed
// distance of the passing item and folds its verdict into the flags.
// ----------------------------------------------------------------------------
module fspc_cell #(
    parameter int COORD_BITS = fspc_pkg::COORD_BITS_DEFAULT,
    parameter int PLANE_IDX  = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fspc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fspc_pkg::PLANE_W-1:0]        cfg_data,
    input  logic                                up_valid,
    output logic                                up_ready,
    input  fspc_pkg::flags_t                    up_flags,
    input  logic signed [COORD_BITS-1:0]        up_cx,
    input  logic signed [COORD_BITS-1:0]        up_cy,
    input  logic signed [COORD_BITS-1:0]        up_cz,
    input  logic [COORD_BITS-2:0]               up_r,
    output logic                                dn_valid,
    input  logic                                dn_ready,
    output fspc_pkg::flags_t                    dn_flags,
    output logic signed [COORD_BITS-1:0]        dn_cx,
    output logic signed [COORD_BITS-1:0]        dn_cy,
    output logic signed [COORD_BITS-1:0]        dn_cz,
    output logic [COORD_BITS-2:0]               dn_r
);
    import fspc_pkg::*;

    localparam int PROD_W = COORD_BITS + NORM_W;
    localparam int DIST_W = (COORD_BITS + 18 > 32) ? COORD_BITS + 18 : 32;
    localparam logic [CFG_IDX_W-1:0] MY_INDEX = plane_reg_index(PLANE_IDX);

    logic [PLANE_W-1:0] plane_reg;

    logic signed [NORM_W-1:0] nx, ny, nz;

    // Product stage.
    logic                         s1_valid_reg;
    flags_t                       s1_flags_reg;
    logic signed [COORD_BITS-1:0] s1_cx_reg, s1_cy_reg, s1_cz_reg;
    logic [COORD_BITS-2:0]        s1_r_reg;
    logic signed [PROD_W-1:0]     s1_px_reg, s1_py_reg, s1_pz_reg;
    logic signed [OFFS_W-1:0]     s1_d_reg;
    logic signed [PROD_W-1:0]     s1_px_next, s1_py_next, s1_pz_next;

    // Decision stage.
    logic                         s2_valid_reg;
    flags_t                       s2_flags_reg;
    flags_t                       s2_flags_next;
    logic signed [COORD_BITS-1:0] s2_cx_reg, s2_cy_reg, s2_cz_reg;
    logic [COORD_BITS-2:0]        s2_r_reg;

    logic signed [DIST_W-1:0] plane_dist;
    logic signed [DIST_W-1:0] r_scaled;
    logic                     s1_load, s2_load, s2_free;

    assign nx = $signed(plane_reg[NORM_W-1:0]);
    assign ny = $signed(plane_reg[2*NORM_W-1:NORM_W]);
    assign nz = $signed(plane_reg[3*NORM_W-1:2*NORM_W]);

    assign s2_free  = !s2_valid_reg || dn_ready;
    assign up_ready = !s1_valid_reg || s2_free;
    assign s1_load  = up_valid && up_ready;
    assign s2_load  = s1_valid_reg && s2_free;

    assign s1_px_next = nx * up_cx;
    assign s1_py_next = ny * up_cy;
    assign s1_pz_next = nz * up_cz;

    assign plane_dist = DIST_W'(s1_px_reg) + DIST_W'(s1_py_reg) + DIST_W'(s1_pz_reg)
                      + (DIST_W'(s1_d_reg) <<< D_SHIFT);
    assign r_scaled = $signed(DIST_W'({s1_r_reg, {D_SHIFT{1'b0}}}));

    always_comb
    begin
        s2_flags_next            = s1_flags_reg;
        s2_flags_next.disjoint   = s1_flags_reg.disjoint || (plane_dist > r_scaled);
        s2_flags_next.all_inside = s1_flags_reg.all_inside && (plane_dist < -r_scaled);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == MY_INDEX)
            begin
                plane_reg <= cfg_data;
            end
            if (up_ready)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_flags_reg <= up_flags;
            s1_cx_reg    <= up_cx;
            s1_cy_reg    <= up_cy;
            s1_cz_reg    <= up_cz;
            s1_r_reg     <= up_r;
            s1_px_reg    <= s1_px_next;
            s1_py_reg    <= s1_py_next;
            s1_pz_reg    <= s1_pz_next;
            s1_d_reg     <= $signed(plane_reg[PLANE_W-1:3*NORM_W]);
        end
        if (s2_load)
        begin
            s2_flags_reg <= s2_flags_next;
            s2_cx_reg    <= s1_cx_reg;
            s2_cy_reg    <= s1_cy_reg;
            s2_cz_reg    <= s1_cz_reg;
            s2_r_reg     <= s1_r_reg;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_flags = s2_flags_reg;
    assign dn_cx    = s2_cx_reg;
    assign dn_cy    = s2_cy_reg;
    assign dn_cz    = s2_cz_reg;
    assign dn_r     = s2_r_reg;

endmodule

// ----- rtl/frustum_sphere_point_cull.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_sphere_point_cull
// Classifies a sphere or a point against six frustum planes.
// ----------------------------------------------------------------------------
// Usage: six 64-bit plane registers are written through cfg_write, cfg_index
// and cfg_data while the block is idle; a write to index six or seven is
// ignored. Each input beat on in_valid/in_ready carries a request type, a
// centre and a radius; each output beat on out_valid/out_ready carries one
// containment code (disjoint, intersects or contains).
// The item passes along a row of six plane cells, each two register stages
// deep (product, then distance and compare); out_valid is the valid of the
// compare stage of the last cell. One beat is taken per cycle for as long
// as the receiver keeps taking results.
// Each stage only needs its successor to be empty or moving, so when the
// receiver stalls the row keeps filling its empty stages and in_ready falls
// only once every stage holds an item. Reset clears all plane registers to
// zero and empties the row.
// ----------------------------------------------------------------------------
module frustum_sphere_point_cull #(
    parameter int COORD_BITS = fspc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [fspc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fspc_pkg::PLANE_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic signed [COORD_BITS-1:0]    center_x,
    input  logic signed [COORD_BITS-1:0]    center_y,
    input  logic signed [COORD_BITS-1:0]    center_z,
    input  logic [COORD_BITS-2:0]           sphere_radius,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fspc_pkg::CONT_W-1:0]     containment
);
    import fspc_pkg::*;

    logic                         ch_valid [NUM_PLANES+1];
    logic                         ch_ready [NUM_PLANES+1];
    flags_t                       ch_flags [NUM_PLANES+1];
    logic signed [COORD_BITS-1:0] ch_cx    [NUM_PLANES+1];
    logic signed [COORD_BITS-1:0] ch_cy    [NUM_PLANES+1];
    logic signed [COORD_BITS-1:0] ch_cz    [NUM_PLANES+1];
    logic [COORD_BITS-2:0]        ch_r     [NUM_PLANES+1];

    flags_t last_flags;

    // A point is tested against a radius of zero.
    assign ch_valid[0]            = in_valid;
    assign in_ready               = ch_ready[0];
    assign ch_flags[0].is_point   = req_type;
    assign ch_flags[0].disjoint   = 1'b0;
    assign ch_flags[0].all_inside = 1'b1;
    assign ch_cx[0]               = center_x;
    assign ch_cy[0]               = center_y;
    assign ch_cz[0]               = center_z;
    assign ch_r[0]                = req_type ? '0 : sphere_radius;

    for (genvar i = 0; i < NUM_PLANES; i++)
    begin : g_cell
        fspc_cell #(
            .COORD_BITS (COORD_BITS),
            .PLANE_IDX  (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg_write (cfg_write),
            .cfg_index (cfg_index),
            .cfg_data  (cfg_data),
            .up_valid  (ch_valid[i]),
            .up_ready  (ch_ready[i]),
            .up_flags  (ch_flags[i]),
            .up_cx     (ch_cx[i]),
            .up_cy     (ch_cy[i]),
            .up_cz     (ch_cz[i]),
            .up_r      (ch_r[i]),
            .dn_valid  (ch_valid[i+1]),
            .dn_ready  (ch_ready[i+1]),
            .dn_flags  (ch_flags[i+1]),
            .dn_cx     (ch_cx[i+1]),
            .dn_cy     (ch_cy[i+1]),
            .dn_cz     (ch_cz[i+1]),
            .dn_r      (ch_r[i+1])
        );
    end

    assign out_valid            = ch_valid[NUM_PLANES];
    assign ch_ready[NUM_PLANES] = out_ready;
    assign last_flags           = ch_flags[NUM_PLANES];

    always_comb
    begin
        if (last_flags.disjoint)
        begin
            containment = CONT_DISJOINT;
        end
        else if (last_flags.is_point || last_flags.all_inside)
        begin
            containment = CONT_CONTAINS;
        end
        else
        begin
            containment = CONT_INTERSECTS;
        end
    end

endmodule
